// File: rtl/http_chunked_body_decoder_defines.svh
// assertion helpers
`ifndef HTTP_CHUNKED_BODY_DECODER_DEFINES_SVH
`define HTTP_CHUNKED_BODY_DECODER_DEFINES_SVH

`define HCBD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`define HCBD_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/hcbd_pkg.sv
`timescale 1ns / 1ps
package hcbd_pkg;

   localparam int SIZE_WIDTH_DEF = 32;
   localparam int LINE_COUNT_WIDTH_DEF = 16;

   localparam logic [2:0] CSR_MAX_LINE = 3'd0;
   localparam logic [2:0] CSR_MAX_HDR_BYTES = 3'd1;
   localparam logic [2:0] CSR_MAX_HDR_COUNT = 3'd2;
   localparam logic [2:0] CSR_MAX_BODY = 3'd3;
   localparam logic [2:0] CSR_HEAD_BYTES = 3'd4;
   localparam logic [2:0] CSR_HEAD_FIELDS = 3'd5;

   localparam logic [2:0] PH_SIZE = 3'd0;
   localparam logic [2:0] PH_DATA = 3'd1;
   localparam logic [2:0] PH_DCR = 3'd2;
   localparam logic [2:0] PH_DLF = 3'd3;
   localparam logic [2:0] PH_DLF_BAD = 3'd4;
   localparam logic [2:0] PH_TRAILER = 3'd5;
   localparam logic [2:0] PH_DONE = 3'd6;

   localparam logic [3:0] ST_BUSY = 4'd0;
   localparam logic [3:0] ST_DONE = 4'd1;
   localparam logic [3:0] ST_BAD_CRLF = 4'd2;
   localparam logic [3:0] ST_FORBID = 4'd3;
   localparam logic [3:0] ST_EMPTY = 4'd4;
   localparam logic [3:0] ST_NONHEX = 4'd5;
   localparam logic [3:0] ST_OVER = 4'd6;
   localparam logic [3:0] ST_LINE_LIM = 4'd7;
   localparam logic [3:0] ST_BODY_LIM = 4'd8;
   localparam logic [3:0] ST_NO_CRLF = 4'd9;
   localparam logic [3:0] ST_EOF = 4'd10;
   localparam logic [3:0] ST_TR_BYTES = 4'd11;
   localparam logic [3:0] ST_TR_COUNT = 4'd12;
   localparam logic [3:0] ST_FOLDED = 4'd13;
   localparam logic [3:0] ST_NO_COLON = 4'd14;
   localparam logic [3:0] ST_FORBID_TR = 4'd15;

   typedef struct packed {
      logic [7:0] max_line_bytes;
      logic [7:0] max_line_bytes_hi;
      logic [15:0] hdr_byte_limit;
      logic [7:0] hdr_field_limit;
      logic [31:0] body_byte_limit;
      logic [15:0] head_bytes_used;
      logic [7:0] head_fields_used;
   } cfg_type;

   // forbidden trailer name character at position pos, 0 beyond the name
   function automatic logic [7:0] bad_char(input logic [1:0] idx, input logic [4:0] pos);
      logic [7:0] c;
      c = 8'h00;
      case (idx)
         2'd0: begin
            case (pos)
               5'd0: c = "c"; 5'd1: c = "o"; 5'd2: c = "n"; 5'd3: c = "t";
               5'd4: c = "e"; 5'd5: c = "n"; 5'd6: c = "t"; 5'd7: c = "-";
               5'd8: c = "l"; 5'd9: c = "e"; 5'd10: c = "n"; 5'd11: c = "g";
               5'd12: c = "t"; 5'd13: c = "h";
               default: c = 8'h00;
            endcase
         end
         2'd1: begin
            case (pos)
               5'd0: c = "t"; 5'd1: c = "r"; 5'd2: c = "a"; 5'd3: c = "n";
               5'd4: c = "s"; 5'd5: c = "f"; 5'd6: c = "e"; 5'd7: c = "r";
               5'd8: c = "-"; 5'd9: c = "e"; 5'd10: c = "n"; 5'd11: c = "c";
               5'd12: c = "o"; 5'd13: c = "d"; 5'd14: c = "i"; 5'd15: c = "n";
               5'd16: c = "g";
               default: c = 8'h00;
            endcase
         end
         2'd2: begin
            case (pos)
               5'd0: c = "h"; 5'd1: c = "o"; 5'd2: c = "s"; 5'd3: c = "t";
               default: c = 8'h00;
            endcase
         end
         default: begin
            case (pos)
               5'd0: c = "t"; 5'd1: c = "r"; 5'd2: c = "a"; 5'd3: c = "i";
               5'd4: c = "l"; 5'd5: c = "e"; 5'd6: c = "r";
               default: c = 8'h00;
            endcase
         end
      endcase
      return c;
   endfunction

   function automatic logic [4:0] bad_len(input logic [1:0] idx);
      logic [4:0] n;
      case (idx)
         2'd0: n = 5'd14;
         2'd1: n = 5'd17;
         2'd2: n = 5'd4;
         default: n = 5'd7;
      endcase
      return n;
   endfunction

   function automatic logic [4:0] hex_val(input logic [7:0] b);
      logic [4:0] d;
      if (b >= "0" && b <= "9") d = {1'b0, b[3:0]};
      else if ((b >= "a" && b <= "f") || (b >= "A" && b <= "F")) d = {1'b0, b[3:0]} + 5'd9;
      else d = 5'd16;
      return d;
   endfunction

endpackage

// File: rtl/hcbd_csr.sv
`timescale 1ns / 1ps
module hcbd_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write,
   input  logic [2:0]        csr_index,
   input  logic [31:0]       csr_data,
   output hcbd_pkg::cfg_type cfg
);

   hcbd_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            hcbd_pkg::CSR_MAX_LINE:
               {cfg_in.max_line_bytes_hi, cfg_in.max_line_bytes} = csr_data[15:0];
            hcbd_pkg::CSR_MAX_HDR_BYTES: cfg_in.hdr_byte_limit = csr_data[15:0];
            hcbd_pkg::CSR_MAX_HDR_COUNT: cfg_in.hdr_field_limit = csr_data[7:0];
            hcbd_pkg::CSR_MAX_BODY: cfg_in.body_byte_limit = csr_data;
            hcbd_pkg::CSR_HEAD_BYTES: cfg_in.head_bytes_used = csr_data[15:0];
            hcbd_pkg::CSR_HEAD_FIELDS: cfg_in.head_fields_used = csr_data[7:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_line_bytes <= 8'h00;
         cfg_ff.max_line_bytes_hi <= 8'h20;
         cfg_ff.hdr_byte_limit <= 16'd16384;
         cfg_ff.hdr_field_limit <= 8'd100;
         cfg_ff.body_byte_limit <= 32'd16777216;
         cfg_ff.head_bytes_used <= 16'd0;
         cfg_ff.head_fields_used <= 8'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/hcbd_core.sv
`timescale 1ns / 1ps
`include "http_chunked_body_decoder_defines.svh"
module hcbd_core #(
   parameter int SIZE_WIDTH = hcbd_pkg::SIZE_WIDTH_DEF,
   parameter int LINE_COUNT_WIDTH = hcbd_pkg::LINE_COUNT_WIDTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  hcbd_pkg::cfg_type cfg,
   input  logic              step,
   input  logic [7:0]        in_byte,
   input  logic              stream_end,
   output logic [7:0]        data_byte,
   output logic              data_valid,
   output logic [3:0]        status
);

   localparam logic [SIZE_WIDTH-1:0] SIZE_ONES = {SIZE_WIDTH{1'b1}};
   localparam logic [LINE_COUNT_WIDTH-1:0] LINE_ONES = {LINE_COUNT_WIDTH{1'b1}};

   logic [2:0] phase_ff, phase_in;
   logic [SIZE_WIDTH-1:0] chunk_ff, chunk_in;
   logic [31:0] body_ff, body_in;
   logic [LINE_COUNT_WIDTH-1:0] len_ff, len_in;
   logic f_forbid_ff, f_forbid_in, f_nonhex_ff, f_nonhex_in, f_over_ff, f_over_in;
   logic f_semi_ff, f_semi_in, f_nonempty_ff, f_nonempty_in, f_cr_ff, f_cr_in;
   logic f_folded_ff, f_folded_in, f_colon_ff, f_colon_in;
   logic [15:0] hbytes_ff, hbytes_in;
   logic [7:0] hfields_ff, hfields_in;
   logic [3:0] mask_ff, mask_in;
   logic forbid_seen_ff, forbid_seen_in;
   logic [3:0] final_ff, final_in;

   logic [15:0] max_line;
   logic [15:0] room;
   logic [31:0] body_room;
   logic [32:0] line_plus2;
   logic [16:0] limit;
   logic [4:0] hexd;
   logic [7:0] low_b;
   logic [3:0] st;
   logic fin;
   logic over_chk;

   assign max_line = {cfg.max_line_bytes_hi, cfg.max_line_bytes};
   assign room = (cfg.hdr_byte_limit > hbytes_ff) ? cfg.hdr_byte_limit - hbytes_ff : 16'd0;
   assign body_room = (cfg.body_byte_limit > body_ff) ? cfg.body_byte_limit - body_ff : 32'd0;
   assign hexd = hcbd_pkg::hex_val(in_byte);
   assign low_b = (in_byte >= "A" && in_byte <= "Z") ? in_byte + 8'd32 : in_byte;
   // chunk*16+d exceeds the counter iff the top nibble is nonzero or the add carries
   assign over_chk = (chunk_ff[SIZE_WIDTH-1 -: 4] != 4'd0) ||
      ({chunk_ff[SIZE_WIDTH-5:0], 4'd0} > (SIZE_ONES - {{(SIZE_WIDTH-4){1'b0}}, hexd[3:0]}));

   always_comb begin
      phase_in = phase_ff; chunk_in = chunk_ff; body_in = body_ff; len_in = len_ff;
      f_forbid_in = f_forbid_ff; f_nonhex_in = f_nonhex_ff; f_over_in = f_over_ff;
      f_semi_in = f_semi_ff; f_nonempty_in = f_nonempty_ff; f_cr_in = f_cr_ff;
      f_folded_in = f_folded_ff; f_colon_in = f_colon_ff;
      hbytes_in = hbytes_ff; hfields_in = hfields_ff; mask_in = mask_ff;
      forbid_seen_in = forbid_seen_ff; final_in = final_ff;
      st = hcbd_pkg::ST_BUSY; fin = 1'b0;
      data_byte = 8'd0; data_valid = 1'b0;
      line_plus2 = 33'(len_ff) + 33'd2;
      limit = '0;
      if (phase_ff == hcbd_pkg::PH_DONE) begin
         st = final_ff;
      end else if (stream_end) begin
         fin = 1'b1;
         st = (phase_ff == hcbd_pkg::PH_DCR || phase_ff == hcbd_pkg::PH_DLF ||
               phase_ff == hcbd_pkg::PH_DLF_BAD) ? hcbd_pkg::ST_NO_CRLF : hcbd_pkg::ST_EOF;
      end else if (phase_ff == hcbd_pkg::PH_DATA) begin
         data_byte = in_byte; data_valid = 1'b1;
         body_in = body_ff + 32'd1;
         chunk_in = chunk_ff - 1'b1;
         if (chunk_in == '0) phase_in = hcbd_pkg::PH_DCR;
      end else if (phase_ff == hcbd_pkg::PH_DCR) begin
         phase_in = (in_byte == 8'h0D) ? hcbd_pkg::PH_DLF : hcbd_pkg::PH_DLF_BAD;
      end else if (phase_ff == hcbd_pkg::PH_DLF) begin
         if (in_byte == 8'h0A) begin
            len_in = '0; {f_forbid_in, f_nonhex_in, f_over_in, f_semi_in} = '0;
            {f_nonempty_in, f_cr_in, f_folded_in, f_colon_in} = '0; mask_in = 4'hF;
            chunk_in = '0; phase_in = hcbd_pkg::PH_SIZE;
         end else begin
            fin = 1'b1; st = hcbd_pkg::ST_NO_CRLF;
         end
      end else if (phase_ff == hcbd_pkg::PH_DLF_BAD) begin
         fin = 1'b1; st = hcbd_pkg::ST_NO_CRLF;
      end else if (f_cr_ff) begin
         if (in_byte != 8'h0A) begin
            fin = 1'b1; st = hcbd_pkg::ST_BAD_CRLF;
         end else begin
            len_in = '0; {f_forbid_in, f_nonhex_in, f_over_in, f_semi_in} = '0;
            {f_nonempty_in, f_cr_in, f_folded_in, f_colon_in} = '0; mask_in = 4'hF;
            if (phase_ff == hcbd_pkg::PH_SIZE) begin
               if (f_forbid_ff) begin fin = 1'b1; st = hcbd_pkg::ST_FORBID; end
               else if (!f_nonempty_ff) begin fin = 1'b1; st = hcbd_pkg::ST_EMPTY; end
               else if (f_nonhex_ff) begin fin = 1'b1; st = hcbd_pkg::ST_NONHEX; end
               else if (f_over_ff) begin fin = 1'b1; st = hcbd_pkg::ST_OVER; end
               else if (chunk_ff == '0) begin
                  hbytes_in = cfg.head_bytes_used; hfields_in = cfg.head_fields_used;
                  forbid_seen_in = 1'b0; phase_in = hcbd_pkg::PH_TRAILER;
                  if (cfg.head_bytes_used >= cfg.hdr_byte_limit) begin
                     fin = 1'b1; st = hcbd_pkg::ST_TR_BYTES;
                  end
               end else if (64'(chunk_ff) > 64'(body_room)) begin
                  fin = 1'b1; st = hcbd_pkg::ST_BODY_LIM;
               end else begin
                  phase_in = hcbd_pkg::PH_DATA;
               end
            end else begin
               // trailer line length never exceeds room, which fits 16 bits
               if (line_plus2 > 33'(room)) begin
                  fin = 1'b1; st = hcbd_pkg::ST_TR_BYTES;
               end else begin
                  hbytes_in = hbytes_ff + line_plus2[15:0];
                  if (len_ff == '0) begin
                     fin = 1'b1;
                     st = forbid_seen_ff ? hcbd_pkg::ST_FORBID_TR : hcbd_pkg::ST_DONE;
                  end else if (f_folded_ff) begin fin = 1'b1; st = hcbd_pkg::ST_FOLDED; end
                  else if (hfields_ff >= cfg.hdr_field_limit) begin
                     fin = 1'b1; st = hcbd_pkg::ST_TR_COUNT;
                  end else if (!f_colon_ff) begin fin = 1'b1; st = hcbd_pkg::ST_NO_COLON; end
                  else begin
                     hfields_in = hfields_ff + 8'd1;
                     if (hbytes_in >= cfg.hdr_byte_limit) begin
                        fin = 1'b1; st = hcbd_pkg::ST_TR_BYTES;
                     end
                  end
               end
            end
         end
      end else if (in_byte == 8'h0D) begin
         f_cr_in = 1'b1;
      end else if (in_byte == 8'h0A) begin
         fin = 1'b1; st = hcbd_pkg::ST_BAD_CRLF;
      end else begin
         limit = (phase_ff == hcbd_pkg::PH_SIZE) ? {1'b0, max_line} : {1'b0, room};
         if (33'(len_ff) >= 33'(limit) || len_ff == LINE_ONES) begin
            fin = 1'b1;
            st = (phase_ff == hcbd_pkg::PH_SIZE) ? hcbd_pkg::ST_LINE_LIM : hcbd_pkg::ST_TR_BYTES;
         end else begin
            len_in = len_ff + 1'b1;
            if (phase_ff == hcbd_pkg::PH_SIZE) begin
               if ((in_byte < 8'h20 && in_byte != 8'h09) || in_byte == 8'h7F) f_forbid_in = 1'b1;
               if (!f_semi_ff) begin
                  if (in_byte == ";") begin
                     f_semi_in = 1'b1;
                  end else begin
                     f_nonempty_in = 1'b1;
                     if (!f_nonhex_ff && !f_over_ff) begin
                        if (hexd[4]) f_nonhex_in = 1'b1;
                        else if (over_chk) f_over_in = 1'b1;
                        else chunk_in = {chunk_ff[SIZE_WIDTH-5:0], hexd[3:0]};
                     end
                  end
               end
            end else begin
               if (len_ff == '0 && (in_byte == 8'h20 || in_byte == 8'h09)) f_folded_in = 1'b1;
               if (!f_colon_ff) begin
                  if (in_byte == ":") begin
                     f_colon_in = 1'b1;
                     for (int i = 0; i < 4; i++) begin
                        if (mask_ff[i] && len_ff ==
                            LINE_COUNT_WIDTH'(hcbd_pkg::bad_len(2'(i))))
                           forbid_seen_in = 1'b1;
                     end
                  end else begin
                     for (int i = 0; i < 4; i++) begin
                        if (len_ff >= LINE_COUNT_WIDTH'(hcbd_pkg::bad_len(2'(i))) ||
                            low_b != hcbd_pkg::bad_char(2'(i), len_ff[4:0]))
                           mask_in[i] = 1'b0;
                     end
                  end
               end
            end
         end
      end
      if (fin) begin
         final_in = st; phase_in = hcbd_pkg::PH_DONE;
      end
   end

   assign status = st;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= hcbd_pkg::PH_SIZE; chunk_ff <= '0; body_ff <= '0; len_ff <= '0;
         {f_forbid_ff, f_nonhex_ff, f_over_ff, f_semi_ff} <= '0;
         {f_nonempty_ff, f_cr_ff, f_folded_ff, f_colon_ff} <= '0;
         hbytes_ff <= '0; hfields_ff <= '0; mask_ff <= 4'hF;
         forbid_seen_ff <= 1'b0; final_ff <= hcbd_pkg::ST_BUSY;
      end else if (step) begin
         phase_ff <= phase_in; chunk_ff <= chunk_in; body_ff <= body_in; len_ff <= len_in;
         {f_forbid_ff, f_nonhex_ff, f_over_ff, f_semi_ff} <=
            {f_forbid_in, f_nonhex_in, f_over_in, f_semi_in};
         {f_nonempty_ff, f_cr_ff, f_folded_ff, f_colon_ff} <=
            {f_nonempty_in, f_cr_in, f_folded_in, f_colon_in};
         hbytes_ff <= hbytes_in; hfields_ff <= hfields_in; mask_ff <= mask_in;
         forbid_seen_ff <= forbid_seen_in; final_ff <= final_in;
      end
   end

   `HCBD_ASSERT(a_done_holds, clock, reset,
      $past(phase_ff == hcbd_pkg::PH_DONE) |-> phase_ff == hcbd_pkg::PH_DONE,
      "final status left")
   `HCBD_ASSERT(a_data_chunk, clock, reset,
      phase_ff == hcbd_pkg::PH_DATA |-> chunk_ff != '0, "data phase with empty chunk")
   `HCBD_ASSERT(a_data_valid, clock, reset,
      data_valid |-> phase_ff == hcbd_pkg::PH_DATA && st == hcbd_pkg::ST_BUSY,
      "data outside payload")

endmodule

// File: rtl/http_chunked_body_decoder.sv
`timescale 1ns / 1ps
`include "http_chunked_body_decoder_defines.svh"
// result register captures the core output on each input transfer
// throughput: one byte per cycle if not stalled, set by the one-pass parser update
// result register accepts input whenever it is empty or being drained
// reset: synchronous, active high; parser to size line start, limits to defaults
module http_chunked_body_decoder #(
   parameter int SIZE_WIDTH = hcbd_pkg::SIZE_WIDTH_DEF,
   parameter int LINE_COUNT_WIDTH = hcbd_pkg::LINE_COUNT_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        req_stream_end,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_data_byte,
   output logic        rsp_data_valid,
   output logic [3:0]  rsp_status
);

   hcbd_pkg::cfg_type cfg;
   logic step;
   logic [7:0] db;
   logic dv;
   logic [3:0] st;
   logic valid_ff, valid_in;
   logic [7:0] db_ff;
   logic dv_ff;
   logic [3:0] st_ff;

   hcbd_csr u_csr (
      .clock(clock), .reset(reset), .csr_write(csr_write), .csr_index(csr_index),
      .csr_data(csr_data), .cfg(cfg)
   );

   assign req_ready = !valid_ff || rsp_ready;
   assign step = req_valid && req_ready;

   hcbd_core #(.SIZE_WIDTH(SIZE_WIDTH), .LINE_COUNT_WIDTH(LINE_COUNT_WIDTH)) u_core (
      .clock(clock), .reset(reset), .cfg(cfg), .step(step), .in_byte(req_in_byte),
      .stream_end(req_stream_end), .data_byte(db), .data_valid(dv), .status(st)
   );

   assign valid_in = step || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (step) begin
         db_ff <= db; dv_ff <= dv; st_ff <= st;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data_byte = db_ff;
   assign rsp_data_valid = dv_ff;
   assign rsp_status = st_ff;

   `HCBD_ASSERT(a_stall_blocks, clock, reset,
      valid_ff && !rsp_ready |-> !req_ready, "input taken over held result")
   `HCBD_ASSERT_NR(a_reset_empty, clock, $past(reset) |-> !rsp_valid, "result after reset")

endmodule
